// ===== rtl/mstt_pkg.sv =====
// ----------------------------------------------------------------------------
// mstt_pkg: shared types and constants of the periodic timer table
// Slot count, field widths, codes and the structs passed between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mstt_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int IDX_W       = $clog2(SLOTS + 1);
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int ID_W        = 32;
  localparam int IV_W        = 32;
  localparam int SLOT_FW     = 4;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_EXPIRY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_ADD   = 2'd1,
    S_WALK  = 2'd2,
    S_FLUSH = 2'd3
  } state_t;

  typedef enum logic {
    ALU_DEC = 1'b0,
    ALU_CMP = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic              single;
    logic [IV_W-1:0]   interval;
    logic [IV_W-1:0]   remaining;
    logic [ID_W-1:0]   ident;
  } ent_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    ent_t              wr_data;
  } mem_req_t;

  typedef struct packed {
    logic               last;
    kind_t              kind;
    status_t            status;
    logic [ID_W-1:0]    timer_id;
    logic [SLOT_FW-1:0] slot;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } emit_t;

endpackage

`default_nettype wire

// ===== rtl/mstt_slot_mem.sv =====
// ----------------------------------------------------------------------------
// mstt_slot_mem: slot entry memory
// One write port and one registered read port over the slot entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mstt_slot_mem (
  input  wire               clk,
  input  mstt_pkg::mem_req_t req,
  output mstt_pkg::ent_t     rd_data_r
);
  import mstt_pkg::*;

  ent_t slot_mem_r [SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      slot_mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= slot_mem_r[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mstt_alu.sv =====
// ----------------------------------------------------------------------------
// mstt_alu: shared subtract and zero-detect unit
// Decrements a remaining count or compares an identifier with the target.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mstt_alu (
  input  mstt_pkg::alu_op_t        op,
  input  wire [mstt_pkg::ID_W-1:0] a,
  input  wire [mstt_pkg::ID_W-1:0] b,
  output logic [mstt_pkg::ID_W-1:0] diff,
  output logic                      zero
);
  import mstt_pkg::*;

  logic [ID_W-1:0] operand;

  always_comb begin
    operand = (op == ALU_DEC) ? ID_W'(1) : b;
    diff    = a - operand;
    zero    = (diff == '0);
  end

endmodule

`default_nettype wire

// ===== rtl/mstt_out_reg.sv =====
// ----------------------------------------------------------------------------
// mstt_out_reg: result output register
// Holds one result word for the output channel and frees the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mstt_out_reg (
  input  wire             clk,
  input  wire             rst_n,
  input  mstt_pkg::emit_t emit,
  output logic            emit_ready,
  output logic            out_valid_r,
  input  wire             out_ready,
  output mstt_pkg::res_t  out_res_r
);
  import mstt_pkg::*;

  assign emit_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_ready) begin
      out_valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit.valid) begin
      out_res_r <= emit.res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mstt_seq.sv =====
// ----------------------------------------------------------------------------
// mstt_seq: timer table sequencer
// Walks the slots one per cycle unless the output stalls, for ticks, searches
// and removes; keeps the valid bits, rotating pointer and identifier counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mstt_seq (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire [1:0]                 in_action,
  input  wire [mstt_pkg::IV_W-1:0]  in_interval,
  input  wire                       in_one_shot,
  input  wire [mstt_pkg::ID_W-1:0]  in_target_id,
  output mstt_pkg::mem_req_t        mem_req,
  input  mstt_pkg::ent_t            mem_rd_data,
  output mstt_pkg::alu_op_t         alu_op,
  output logic [mstt_pkg::ID_W-1:0] alu_a,
  output logic [mstt_pkg::ID_W-1:0] alu_b,
  input  wire [mstt_pkg::ID_W-1:0]  alu_diff,
  input  wire                       alu_zero,
  output mstt_pkg::emit_t           emit,
  input  wire                       emit_ready
);
  import mstt_pkg::*;

  state_t            state_r, state_nxt;
  action_t           act_r, act_nxt;
  logic [IV_W-1:0]   iv_r, iv_nxt;
  logic              single_r, single_nxt;
  logic [ID_W-1:0]   target_r, target_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [SLOT_W-1:0] ex_idx_r, ex_idx_nxt;
  logic              ex_vld_r, ex_vld_nxt;
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [SLOT_W-1:0] next_slot_r, next_slot_nxt;
  logic [ID_W-1:0]   ident_r, ident_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  res_t              pend_r, pend_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;

  logic              in_fire;
  action_t           in_act;
  logic              add_direct;
  logic              issue_ok;
  logic              walk_end;
  logic              slot_busy;
  logic              tick_live;
  logic              tick_hit;
  logic              report;
  logic              stall;
  logic              add_hit;
  logic              rm_hit;
  logic [SLOT_W-1:0] slot_inc;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    in_fire    = in_valid && in_ready;
    in_act     = action_t'(in_action);
    add_direct = !valid_r[next_slot_r];
    issue_ok   = (idx_r < IDX_W'(SLOTS));
    walk_end   = !ex_vld_r && !issue_ok;
    slot_busy  = valid_r[ex_idx_r];
    tick_live  = (act_r == ACT_TICK) && ex_vld_r && slot_busy;
    tick_hit   = tick_live && alu_zero;
    report     = tick_hit && (res_cnt_r < CNT_W'(MAX_RESULTS));
    stall      = report && pend_valid_r && !emit_ready;
    add_hit    = (act_r == ACT_ADD) && ex_vld_r && !slot_busy;
    rm_hit     = (act_r == ACT_REMOVE) && ex_vld_r && slot_busy && alu_zero;
    slot_inc   = (next_slot_r == SLOT_W'(SLOTS - 1)) ? '0 : next_slot_r + 1'b1;
    alu_op     = (act_r == ACT_TICK) ? ALU_DEC : ALU_CMP;
    alu_a      = (act_r == ACT_TICK) ? mem_rd_data.remaining : mem_rd_data.ident;
    alu_b      = target_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_act)
            ACT_TICK:   state_nxt = S_WALK;
            ACT_ADD: begin
              if (in_interval == '0) begin
                state_nxt = S_FLUSH;
              end else if (add_direct) begin
                state_nxt = S_ADD;
              end else begin
                state_nxt = S_WALK;
              end
            end
            ACT_REMOVE: state_nxt = S_WALK;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD:   state_nxt = S_FLUSH;
      S_WALK: begin
        if (add_hit || rm_hit || walk_end) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r || emit_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    act_nxt        = act_r;
    iv_nxt         = iv_r;
    single_nxt     = single_r;
    target_nxt     = target_r;
    idx_nxt        = idx_r;
    ex_idx_nxt     = ex_idx_r;
    ex_vld_nxt     = ex_vld_r;
    valid_nxt      = valid_r;
    next_slot_nxt  = next_slot_r;
    ident_nxt      = ident_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    res_cnt_nxt    = res_cnt_r;
    mem_req        = '0;
    emit           = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt        = in_act;
          iv_nxt         = in_interval;
          single_nxt     = in_one_shot;
          target_nxt     = in_target_id;
          idx_nxt        = '0;
          ex_vld_nxt     = 1'b0;
          res_cnt_nxt    = '0;
          pend_valid_nxt = 1'b0;
          if ((in_act == ACT_ADD) && (in_interval == '0)) begin
            pend_valid_nxt = 1'b1;
            pend_nxt       = '{last: 1'b0, kind: KIND_ADD, status: ST_ZERO,
                               timer_id: '0, slot: '0};
          end
        end
      end
      S_ADD: begin
        mem_req.wr_en          = 1'b1;
        mem_req.wr_addr        = next_slot_r;
        mem_req.wr_data        = '{single: single_r, interval: iv_r,
                                   remaining: iv_r, ident: ident_r};
        valid_nxt[next_slot_r] = 1'b1;
        next_slot_nxt          = slot_inc;
        ident_nxt              = ident_r + 1'b1;
        pend_valid_nxt         = 1'b1;
        pend_nxt               = '{last: 1'b0, kind: KIND_ADD, status: ST_OK,
                                   timer_id: ident_r, slot: SLOT_FW'(next_slot_r)};
      end
      S_WALK: begin
        if (!stall) begin
          mem_req.rd_en   = issue_ok;
          mem_req.rd_addr = idx_r[SLOT_W-1:0];
          ex_idx_nxt      = idx_r[SLOT_W-1:0];
          ex_vld_nxt      = issue_ok;
          idx_nxt         = idx_r + IDX_W'(issue_ok);

          if (tick_live) begin
            mem_req.wr_addr = ex_idx_r;
            mem_req.wr_data = mem_rd_data;
            if (alu_zero) begin
              if (mem_rd_data.single) begin
                valid_nxt[ex_idx_r] = 1'b0;
              end else begin
                mem_req.wr_en             = 1'b1;
                mem_req.wr_data.remaining = mem_rd_data.interval;
              end
            end else begin
              mem_req.wr_en             = 1'b1;
              mem_req.wr_data.remaining = alu_diff;
            end
          end

          if (report) begin
            emit.valid     = pend_valid_r;
            emit.res       = pend_r;
            pend_valid_nxt = 1'b1;
            pend_nxt       = '{last: 1'b0, kind: KIND_EXPIRY, status: ST_OK,
                               timer_id: mem_rd_data.ident,
                               slot: SLOT_FW'(ex_idx_r)};
            res_cnt_nxt    = res_cnt_r + 1'b1;
          end

          if (add_hit) begin
            mem_req.wr_en       = 1'b1;
            mem_req.wr_addr     = ex_idx_r;
            mem_req.wr_data     = '{single: single_r, interval: iv_r,
                                    remaining: iv_r, ident: ident_r};
            valid_nxt[ex_idx_r] = 1'b1;
            next_slot_nxt       = ex_idx_r;
            ident_nxt           = ident_r + 1'b1;
            pend_valid_nxt      = 1'b1;
            pend_nxt            = '{last: 1'b0, kind: KIND_ADD, status: ST_OK,
                                    timer_id: ident_r, slot: SLOT_FW'(ex_idx_r)};
          end

          if (rm_hit) begin
            valid_nxt[ex_idx_r] = 1'b0;
            next_slot_nxt       = ex_idx_r;
            pend_valid_nxt      = 1'b1;
            pend_nxt            = '{last: 1'b0, kind: KIND_REMOVE, status: ST_OK,
                                    timer_id: target_r, slot: SLOT_FW'(ex_idx_r)};
          end

          if (walk_end) begin
            if (act_r == ACT_ADD) begin
              pend_valid_nxt = 1'b1;
              pend_nxt       = '{last: 1'b0, kind: KIND_ADD, status: ST_FULL,
                                 timer_id: '0, slot: '0};
            end else if (act_r == ACT_REMOVE) begin
              pend_valid_nxt = 1'b1;
              pend_nxt       = '{last: 1'b0, kind: KIND_REMOVE, status: ST_NOT_FOUND,
                                 timer_id: target_r, slot: '0};
            end
          end
        end
      end
      S_FLUSH: begin
        emit.valid    = pend_valid_r;
        emit.res      = pend_r;
        emit.res.last = 1'b1;
        if (emit_ready) begin
          pend_valid_nxt = 1'b0;
        end
      end
      default: begin
        emit = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      next_slot_r  <= '0;
      ident_r      <= '0;
      pend_valid_r <= 1'b0;
      ex_vld_r     <= 1'b0;
      idx_r        <= '0;
      res_cnt_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      next_slot_r  <= next_slot_nxt;
      ident_r      <= ident_nxt;
      pend_valid_r <= pend_valid_nxt;
      ex_vld_r     <= ex_vld_nxt;
      idx_r        <= idx_nxt;
      res_cnt_r    <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    iv_r     <= iv_nxt;
    single_r <= single_nxt;
    target_r <= target_nxt;
    ex_idx_r <= ex_idx_nxt;
    pend_r   <= pend_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/multi_slot_periodic_timer_table_top.sv =====
// ----------------------------------------------------------------------------
// multi_slot_periodic_timer_table_top: periodic timer table
// A table of timer slots with add, remove and tick commands and expiry words.
//
//   channel | dir | handshake          | contents
//   in_     | in  | in_tvalid/tready   | tuser action, tdata interval/one_shot/target
//   out_    | out | out_tvalid/tready  | tuser kind, tdata status/timer_id/slot, tlast
//
// A tick, a remove or an add whose pointer slot is taken walks the slots
// through one decrement/compare unit after a registered memory read, one slot
// per cycle unless the output stalls. A direct add uses the add, then flush state.
// Reset clears the valid bits, the pointer and the identifier counter.
// A stalled output holds the walk at the next expiry that needs to be sent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_slot_periodic_timer_table_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [71:0] in_tdata,   // interval[31:0], one_shot[32], target_id[64:33]
  input  wire  [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // status[1:0], timer_id[33:2], slot[37:34]
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast
);
  import mstt_pkg::*;

  mem_req_t        mem_req;
  ent_t            mem_rd_data;
  alu_op_t         alu_op;
  logic [ID_W-1:0] alu_a;
  logic [ID_W-1:0] alu_b;
  logic [ID_W-1:0] alu_diff;
  logic            alu_zero;
  emit_t           emit;
  logic            emit_ready;
  res_t            out_res;

  mstt_slot_mem u_mem (
    .clk       (clk),
    .req       (mem_req),
    .rd_data_r (mem_rd_data)
  );

  mstt_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .zero (alu_zero)
  );

  mstt_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_action    (in_tuser),
    .in_interval  (in_tdata[31:0]),
    .in_one_shot  (in_tdata[32]),
    .in_target_id (in_tdata[64:33]),
    .mem_req      (mem_req),
    .mem_rd_data  (mem_rd_data),
    .alu_op       (alu_op),
    .alu_a        (alu_a),
    .alu_b        (alu_b),
    .alu_diff     (alu_diff),
    .alu_zero     (alu_zero),
    .emit         (emit),
    .emit_ready   (emit_ready)
  );

  mstt_out_reg u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .emit        (emit),
    .emit_ready  (emit_ready),
    .out_valid_r (out_tvalid),
    .out_ready   (out_tready),
    .out_res_r   (out_res)
  );

  assign out_tdata = {2'b00, out_res.slot, out_res.timer_id, out_res.status};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> !in_tready)
    else $error("result emitted while the sequencer was idle");

  a_none_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (action_t'(in_tuser) == ACT_NONE)) |=> in_tready)
    else $error("unused action code did not return to idle");

  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (kind_t'(out_tuser) != KIND_EXPIRY)) |-> out_tlast)
    else $error("add or remove reply without last");

  a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (kind_t'(out_tuser) == KIND_EXPIRY)) |->
      (status_t'(out_tdata[1:0]) == ST_OK))
    else $error("expiry word with a non-ok status");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the periodic timer table
// Drives tick, add and remove words with random gaps and back-pressure. It
// predicts every reply and expiry word with a model of the slot table, and
// compares the output stream word by word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mstt_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_WORDS = 480;
  localparam int DRAIN_CYCLES = 4 * SLOTS + 20;
  localparam int HOLD_CYCLES  = 400;

  class timer_reply_board;
    bit                valid[SLOTS];
    bit [ID_W-1:0]     ident[SLOTS];
    bit [IV_W-1:0]     period[SLOTS];
    bit [IV_W-1:0]     remaining[SLOTS];
    bit                single[SLOTS];
    bit [SLOT_W-1:0]   ptr;
    bit [ID_W-1:0]     id_ctr;
    res_t              due_words[$];
    int                errors;

    function res_t make_word(kind_t k, status_t st, bit [ID_W-1:0] id, int s);
      res_t r;
      r.last     = 1'b0;
      r.kind     = k;
      r.status   = st;
      r.timer_id = id;
      r.slot     = s[SLOT_FW-1:0];
      return r;
    endfunction

    function void take_command(action_t act, bit [IV_W-1:0] iv, bit os,
                               bit [ID_W-1:0] tgt);
      res_t batch[$];
      int   s;
      bit   found;
      case (act)
        ACT_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (valid[i]) begin
              remaining[i] = remaining[i] - 1;
              if (remaining[i] == 0) begin
                if (batch.size() < MAX_RESULTS) begin
                  batch.push_back(make_word(KIND_EXPIRY, ST_OK, ident[i], i));
                end
                if (single[i]) begin
                  valid[i] = 1'b0;
                end else begin
                  remaining[i] = period[i];
                end
              end
            end
          end
        end
        ACT_ADD: begin
          if (iv == 0) begin
            batch.push_back(make_word(KIND_ADD, ST_ZERO, '0, 0));
          end else begin
            s = ptr;
            found = 1'b0;
            if (!valid[s]) begin
              found = 1'b1;
              ptr = ptr + 1'b1;
            end else begin
              for (int i = 0; i < SLOTS && !found; i++) begin
                if (!valid[i]) begin
                  s = i;
                  found = 1'b1;
                  ptr = i[SLOT_W-1:0];
                end
              end
            end
            if (!found) begin
              batch.push_back(make_word(KIND_ADD, ST_FULL, '0, 0));
            end else begin
              valid[s]     = 1'b1;
              ident[s]     = id_ctr;
              period[s]    = iv;
              remaining[s] = iv;
              single[s]    = os;
              batch.push_back(make_word(KIND_ADD, ST_OK, id_ctr, s));
              id_ctr = id_ctr + 1;
            end
          end
        end
        ACT_REMOVE: begin
          found = 1'b0;
          for (int i = 0; i < SLOTS && !found; i++) begin
            if (valid[i] && ident[i] == tgt) begin
              found = 1'b1;
              valid[i] = 1'b0;
              ptr = i[SLOT_W-1:0];
              batch.push_back(make_word(KIND_REMOVE, ST_OK, tgt, i));
            end
          end
          if (!found) begin
            batch.push_back(make_word(KIND_REMOVE, ST_NOT_FOUND, tgt, 0));
          end
        end
        default: begin
        end
      endcase
      if (batch.size() > 0) begin
        batch[batch.size() - 1].last = 1'b1;
      end
      foreach (batch[i]) begin
        due_words.push_back(batch[i]);
      end
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (due_words.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("tb: unexpected word kind %0d status %0d id %h slot %0d last %0b",
                   got.kind, got.status, got.timer_id, got.slot, got.last);
        end
      end else begin
        want = due_words.pop_front();
        if (got.kind !== want.kind || got.status !== want.status ||
            got.timer_id !== want.timer_id || got.slot !== want.slot ||
            got.last !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("tb: mismatch at %0t: expected kind %0d status %0d id %h slot %0d last %0b",
                     $time, want.kind, want.status, want.timer_id, want.slot, want.last);
            $display("tb:                got      kind %0d status %0d id %h slot %0d last %0b",
                     got.kind, got.status, got.timer_id, got.slot, got.last);
          end
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  timer_reply_board sb = new();
  int send_idle_pct = 31;
  int recv_idle_pct = 73;
  bit hold_req = 1'b0;
  int cycles = 0;

  multi_slot_periodic_timer_table_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // The receiver counts its own long hold-off when one is requested.
  initial begin
    res_t got;
    int   hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.last     = out_tlast;
        got.kind     = kind_t'(out_tuser);
        got.status   = status_t'(out_tdata[1:0]);
        got.timer_id = out_tdata[33:2];
        got.slot     = out_tdata[37:34];
        sb.check_word(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_word(action_t act, logic [31:0] iv, logic os, logic [31:0] tgt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {7'd0, tgt, os, iv};
    do begin
      @(posedge clk);
    end while (!in_tready);
    sb.take_command(act, iv, os, tgt);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return '0;
    end else if (r < 8) begin
      return 32'hFFFF_FFFF;
    end else if (r < 20) begin
      return $urandom;
    end
    return $urandom_range(1, 12);
  endfunction

  function automatic logic [31:0] pick_target();
    int r;
    int s;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, SLOTS - 1);
    if (r < 60 && sb.valid[s]) begin
      return sb.ident[s];
    end else if (r < 85) begin
      return sb.id_ctr - $urandom_range(0, 30);
    end
    return $urandom;
  endfunction

  initial begin
    int pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: empty tick, zero interval, the largest interval, remove
    // hit and miss, the unused action, a full table, then a tick on which
    // every slot expires at once.
    send_word(ACT_TICK, '0, 1'b0, '0);
    send_word(ACT_ADD, '0, 1'b1, 32'hFFFF_FFFF);
    send_word(ACT_ADD, 32'hFFFF_FFFF, 1'b0, '0);
    send_word(ACT_REMOVE, '0, 1'b0, 32'd0);
    send_word(ACT_REMOVE, '0, 1'b1, 32'hFFFF_FFFF);
    send_word(ACT_NONE, $urandom, 1'b1, $urandom);
    for (int i = 0; i < SLOTS; i++) begin
      send_word(ACT_ADD, 32'd3, i[0], $urandom);
    end
    send_word(ACT_ADD, 32'd5, 1'b0, '0);
    repeat (3) send_word(ACT_TICK, $urandom, 1'b1, $urandom);

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k == RANDOM_WORDS / 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 31;
      end else if (k == 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (k == 40) begin
        hold_req = 1'b1;
      end
      if (k == 250) begin
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_word(ACT_TICK, $urandom, $urandom_range(0, 1), $urandom);
      end else if (pick < 80) begin
        send_word(ACT_ADD, pick_interval(), $urandom_range(0, 1), $urandom);
      end else begin
        send_word(ACT_REMOVE, $urandom, $urandom_range(0, 1), pick_target());
      end
      if ($urandom_range(0, 99) < 4) begin
        send_word(ACT_NONE, $urandom, $urandom_range(0, 1), $urandom);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.due_words.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== multi_slot_periodic_timer_table_top.f =====
rtl/mstt_pkg.sv
rtl/mstt_slot_mem.sv
rtl/mstt_alu.sv
rtl/mstt_out_reg.sv
rtl/mstt_seq.sv
rtl/multi_slot_periodic_timer_table_top.sv
test/tb.sv
